@@ design/blsx_pkg.sv @@
// ----------------------------------------------------------------------------
// blsx_pkg
// Shared types, codes and helpers for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package blsx_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int ERR_BITS   = 16;
  localparam int ROT_BITS   = 14;
  localparam int STR_BITS   = 15;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // result queue on the output side
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA_BITS-1:0] delta_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [1:0]            step_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_MAJOR  = 3'b010,
    PH_FINISH = 3'b100
  } phase_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                is_load;
    phase_t              phase;      // starting phase of a load
    coord_t              cur_x;
    coord_t              cur_y;
    coord_t              stop_x;
    coord_t              stop_y;
    logic [ERR_BITS-1:0] err;
    logic [ROT_BITS-1:0] rot_gain;
    logic [STR_BITS-1:0] str_gain;
    step_t               str_sx;
    step_t               str_sy;
    step_t               rot_sx;
    step_t               rot_sy;
    color_t              color;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } res_t;

  // 2-bit step code to a coordinate increment (binary 10 is -2)
  function automatic coord_t step_ext(step_t s);
    step_ext = {{(COORD_BITS-2){s[1]}}, s};
  endfunction

endpackage

@@ design/blsx_front.sv @@
// ----------------------------------------------------------------------------
// blsx_front
// Accepts input words, classifies load/tick, works out the error term and
// gains of a load, and queues the result for the back end.
// ----------------------------------------------------------------------------
module blsx_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_operation,
  input  blsx_pkg::coord_t         in_start_x,
  input  blsx_pkg::coord_t         in_start_y,
  input  blsx_pkg::coord_t         in_end_x,
  input  blsx_pkg::coord_t         in_end_y,
  input  blsx_pkg::delta_t         in_major_delta,
  input  blsx_pkg::delta_t         in_minor_delta,
  input  logic signed [1:0]        in_straight_step_x,
  input  logic signed [1:0]        in_straight_step_y,
  input  logic signed [1:0]        in_rotated_step_x,
  input  logic signed [1:0]        in_rotated_step_y,
  input  blsx_pkg::color_t         in_line_color_in,
  output logic                     cmd_valid,
  output blsx_pkg::cmd_t           cmd_word,
  input  logic                     cmd_pop
);

  blsx_pkg::cmd_t                    cmd_in;
  blsx_pkg::cmd_t                    q_mem [blsx_pkg::CMDQ_DEPTH];
  logic [blsx_pkg::CMDQ_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [blsx_pkg::CMDQ_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [blsx_pkg::CMDQ_CW-1:0]      cnt_r, cnt_nxt;
  logic                              wr_en;
  logic                              rd_en;

  // classify and precompute
  always_comb begin
    cmd_in          = '0;
    cmd_in.is_load  = (in_operation == blsx_pkg::OP_LOAD);
    cmd_in.cur_x    = in_start_x;
    cmd_in.cur_y    = in_start_y;
    cmd_in.stop_x   = in_end_x;
    cmd_in.stop_y   = in_end_y;
    // 2*dy - dx, 2*dy, 2*dy - 2*dx, each wrapping at its own width
    cmd_in.err      = {3'b000, in_minor_delta, 1'b0} - {4'b0000, in_major_delta};
    cmd_in.rot_gain = {1'b0, in_minor_delta, 1'b0};
    cmd_in.str_gain = {2'b00, in_minor_delta, 1'b0} - {2'b00, in_major_delta, 1'b0};
    cmd_in.str_sx   = in_straight_step_x;
    cmd_in.str_sy   = in_straight_step_y;
    cmd_in.rot_sx   = in_rotated_step_x;
    cmd_in.rot_sy   = in_rotated_step_y;
    cmd_in.color    = in_line_color_in;
    if (in_start_x != in_end_x) begin
      cmd_in.phase = blsx_pkg::PH_MAJOR;
    end else if (in_start_y != in_end_y) begin
      cmd_in.phase = blsx_pkg::PH_FINISH;
    end else begin
      cmd_in.phase = blsx_pkg::PH_IDLE;
    end
  end

  assign full      = (cnt_r == blsx_pkg::CMDQ_CW'(blsx_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_word  = q_mem[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + blsx_pkg::CMDQ_AW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + blsx_pkg::CMDQ_AW'(rd_en);
    cnt_nxt    = cnt_r + blsx_pkg::CMDQ_CW'(wr_en) - blsx_pkg::CMDQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy tracks the pointer difference
  a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != blsx_pkg::CMDQ_CW'(blsx_pkg::CMDQ_DEPTH)) |->
      (blsx_pkg::CMDQ_AW'(cnt_r) == blsx_pkg::CMDQ_AW'(wr_ptr_r - rd_ptr_r)))
    else $error("command queue count out of step with pointers");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= blsx_pkg::CMDQ_CW'(blsx_pkg::CMDQ_DEPTH)))
    else $error("command queue overfilled");
`endif

endmodule

@@ design/blsx_back.sv @@
// ----------------------------------------------------------------------------
// blsx_back
// Line stepper: takes queued words, holds the line state, does one
// Bresenham step per tick of an active line and queues the emitted pixel.
// ----------------------------------------------------------------------------
module blsx_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  blsx_pkg::cmd_t           cmd_word,
  output logic                     cmd_pop,
  output logic                     empty,
  input  logic                     pop,
  output blsx_pkg::res_t           res_word
);

  blsx_pkg::phase_t                  phase_r, phase_nxt;
  blsx_pkg::coord_t                  cur_x_r, cur_x_nxt;
  blsx_pkg::coord_t                  cur_y_r, cur_y_nxt;
  blsx_pkg::coord_t                  stop_x_r, stop_y_r;
  logic [blsx_pkg::ERR_BITS-1:0]     err_r, err_nxt;
  logic [blsx_pkg::ROT_BITS-1:0]     rot_gain_r;
  logic [blsx_pkg::STR_BITS-1:0]     str_gain_r;
  blsx_pkg::step_t                   str_sx_r, str_sy_r, rot_sx_r, rot_sy_r;
  blsx_pkg::color_t                  color_r;

  blsx_pkg::res_t                    res_in;
  logic                              res_push;
  logic                              take;
  logic                              neg;

  blsx_pkg::res_t                    rq_mem [blsx_pkg::RESQ_DEPTH];
  logic [blsx_pkg::RESQ_AW-1:0]      rq_wr_r, rq_rd_r;
  logic [blsx_pkg::RESQ_CW-1:0]      rq_cnt_r, rq_cnt_nxt;
  logic                              rq_full;
  logic                              rq_rd_en;

  assign rq_full  = (rq_cnt_r == blsx_pkg::RESQ_CW'(blsx_pkg::RESQ_DEPTH));
  assign empty    = (rq_cnt_r == '0);
  assign rq_rd_en = pop && !empty;
  assign res_word = rq_mem[rq_rd_r];

  // a load never emits, so it goes through even with the result queue full
  assign take    = cmd_valid && (cmd_word.is_load || !rq_full);
  assign cmd_pop = take;
  assign neg     = err_r[blsx_pkg::ERR_BITS-1];

  always_comb begin
    phase_nxt    = phase_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    err_nxt      = err_r;
    res_push     = 1'b0;
    res_in.x     = cur_x_r;
    res_in.y     = cur_y_r;
    res_in.color = color_r;
    res_in.last  = 1'b0;
    if (take && !cmd_word.is_load) begin
      case (phase_r)
        blsx_pkg::PH_MAJOR: begin
          res_push = 1'b1;
          if (!neg) begin
            cur_x_nxt = cur_x_r + blsx_pkg::step_ext(str_sx_r);
            cur_y_nxt = cur_y_r + blsx_pkg::step_ext(str_sy_r);
            err_nxt   = err_r + {str_gain_r[blsx_pkg::STR_BITS-1], str_gain_r};
          end else begin
            cur_x_nxt = cur_x_r + blsx_pkg::step_ext(rot_sx_r);
            cur_y_nxt = cur_y_r + blsx_pkg::step_ext(rot_sy_r);
            err_nxt   = err_r + {2'b00, rot_gain_r};
          end
          if (cur_x_nxt == stop_x_r) begin
            if (cur_y_nxt != stop_y_r) begin
              phase_nxt = blsx_pkg::PH_FINISH;
            end else begin
              phase_nxt   = blsx_pkg::PH_IDLE;
              res_in.last = 1'b1;
            end
          end
        end
        blsx_pkg::PH_FINISH: begin
          res_push  = 1'b1;
          cur_y_nxt = cur_y_r + blsx_pkg::step_ext(str_sy_r);
          if (cur_y_nxt == stop_y_r) begin
            phase_nxt   = blsx_pkg::PH_IDLE;
            res_in.last = 1'b1;
          end
        end
        default: begin
          // idle: a tick is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= blsx_pkg::PH_IDLE;
    end else if (take && cmd_word.is_load) begin
      phase_r <= cmd_word.phase;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd_word.is_load) begin
      cur_x_r    <= cmd_word.cur_x;
      cur_y_r    <= cmd_word.cur_y;
      stop_x_r   <= cmd_word.stop_x;
      stop_y_r   <= cmd_word.stop_y;
      err_r      <= cmd_word.err;
      rot_gain_r <= cmd_word.rot_gain;
      str_gain_r <= cmd_word.str_gain;
      str_sx_r   <= cmd_word.str_sx;
      str_sy_r   <= cmd_word.str_sy;
      rot_sx_r   <= cmd_word.rot_sx;
      rot_sy_r   <= cmd_word.rot_sy;
      color_r    <= cmd_word.color;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  // result queue
  always_comb begin
    rq_cnt_nxt = rq_cnt_r + blsx_pkg::RESQ_CW'(res_push)
               - blsx_pkg::RESQ_CW'(rq_rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      rq_wr_r  <= rq_wr_r + blsx_pkg::RESQ_AW'(res_push);
      rq_rd_r  <= rq_rd_r + blsx_pkg::RESQ_AW'(rq_rd_en);
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq_mem[rq_wr_r] <= res_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !rq_full)
    else $error("pixel pushed into full result queue");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.last) |=> (phase_r == blsx_pkg::PH_IDLE))
    else $error("line still active after its last pixel");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == blsx_pkg::PH_IDLE) |-> !res_push)
    else $error("pixel emitted while idle");
`endif

endmodule

@@ design/bresenham_line_stepper_top.sv @@
// Path: a tick pushed into an empty block reaches out_* through the
// command queue, then the stepper into the result queue.
// Throughput: one word per cycle on both sides, but a tick waits while the
// result queue is full; the error add and compare are combinational.
// Reset: rst_n synchronous, active low; empties both queues, line idle.
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// Integer line rasteriser. Load words latch a line, tick words each emit one
// pixel. Front end classifies and precomputes, back end steps the line.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top (
  input  logic                     clk,
  input  logic                     rst_n,
  // input queue side
  input  logic                     push,
  output logic                     full,
  input  logic                     in_operation,
  input  blsx_pkg::coord_t         in_start_x,
  input  blsx_pkg::coord_t         in_start_y,
  input  blsx_pkg::coord_t         in_end_x,
  input  blsx_pkg::coord_t         in_end_y,
  input  blsx_pkg::delta_t         in_major_delta,
  input  blsx_pkg::delta_t         in_minor_delta,
  input  logic signed [1:0]        in_straight_step_x,
  input  logic signed [1:0]        in_straight_step_y,
  input  logic signed [1:0]        in_rotated_step_x,
  input  logic signed [1:0]        in_rotated_step_y,
  input  blsx_pkg::color_t         in_line_color_in,
  // result queue side
  output logic                     empty,
  input  logic                     pop,
  output blsx_pkg::coord_t         out_pixel_x,
  output blsx_pkg::coord_t         out_pixel_y,
  output blsx_pkg::color_t         out_pixel_color,
  output logic                     out_last_pixel
);

  // front to back: classified words, four deep so a stalled back end
  // does not hold up the sender at once
  logic           cmd_valid;
  logic           cmd_pop;
  blsx_pkg::cmd_t cmd_word;
  blsx_pkg::res_t res_word;

  blsx_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_operation       (in_operation),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_major_delta     (in_major_delta),
    .in_minor_delta     (in_minor_delta),
    .in_straight_step_x (in_straight_step_x),
    .in_straight_step_y (in_straight_step_y),
    .in_rotated_step_x  (in_rotated_step_x),
    .in_rotated_step_y  (in_rotated_step_y),
    .in_line_color_in   (in_line_color_in),
    .cmd_valid          (cmd_valid),
    .cmd_word           (cmd_word),
    .cmd_pop            (cmd_pop)
  );

  // back end: one step per tick, a two-entry result queue decouples pop
  blsx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res_word  (res_word)
  );

  assign out_pixel_x     = res_word.x;
  assign out_pixel_y     = res_word.y;
  assign out_pixel_color = res_word.color;
  assign out_last_pixel  = res_word.last;

endmodule
